/* sv/dstr_pkg.sv */
package dstr_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned NUM_W   = 16;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned PROD_W  = NUM_W + 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_YEAR_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YEAR_HI = 2'd1;

	localparam logic [NUM_W-1:0] YEAR_LO_RST  = 16'd1900;
	localparam logic [NUM_W-1:0] YEAR_HI_RST  = 16'd2100;
	localparam logic [NUM_W-1:0] ACC_MAX      = 16'hFFFF;
	localparam logic [NUM_W-1:0] DAY_LIMIT    = 16'd31;

	// Multiplicative inverse of 25 modulo 2**16 and the largest quotient of a
	// multiple of 25 that fits in 16 bits.
	localparam logic [NUM_W-1:0] INV25       = 16'h5C29;
	localparam logic [NUM_W-1:0] DIV25_LIMIT = 16'd2621;

	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;

	typedef struct packed {
		logic               done;
		logic               year_first;
		logic [NUM_W-1:0]   first_number;
		logic [MONTH_W-1:0] month;
		logic [NUM_W-1:0]   accumulator;
	} dstr_cand_t;

	typedef struct packed {
		logic               valid_res;
		logic [NUM_W-1:0]   year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} dstr_res_t;

	function automatic logic year_ok(input logic [NUM_W-1:0] y,
			input logic [NUM_W-1:0] lo, input logic [NUM_W-1:0] hi);
		return (y >= lo) && (y <= hi);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_DOT) ||
			(c == CH_DASH) || (c == CH_COLON);
	endfunction

	function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = leap ? 5'd29 : 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

/* sv/dstr_check.sv */
module dstr_check (
	input  dstr_pkg::dstr_cand_t     cand,
	input  logic [dstr_pkg::NUM_W-1:0] year_lo,
	input  logic [dstr_pkg::NUM_W-1:0] year_hi,
	output dstr_pkg::dstr_res_t      res
);
	import dstr_pkg::*;

	logic [NUM_W-1:0]   y;
	logic [NUM_W-1:0]   d;
	logic [NUM_W-1:0]   prod25;
	logic               div25;
	logic               leap;
	logic [DAY_W-1:0]   mdays;
	logic               ok;

	assign y = cand.year_first ? cand.first_number : cand.accumulator;
	assign d = cand.year_first ? cand.accumulator : cand.first_number;

	// A multiple of 25 times the inverse of 25 lands on its own quotient.
	assign prod25 = y * INV25;
	assign div25  = prod25 <= DIV25_LIMIT;
	assign leap   = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	assign mdays  = days_in_month(cand.month, leap);

	assign ok = cand.done && (cand.year_first || year_ok(y, year_lo, year_hi)) &&
		(d != '0) && (d <= {{(NUM_W-DAY_W){1'b0}}, mdays});

	always_comb begin
		res = '0;
		if (ok) begin
			res.valid_res = 1'b1;
			res.year      = y;
			res.month     = cand.month;
			res.day       = d[DAY_W-1:0];
		end
	end

endmodule

/* sv/date_string_parser.sv */
// Date string parser.
// A string arrives on the s_ group one character per request, with s_tlast on
// its final character. Leading whitespace is skipped, then three numbers split
// by / \ . - or : are read in day.month.year order, or year/month/day order
// when the first number exceeds 31. For every string one result request
// leaves on the m_ group: m_tuser flags a valid date and m_tdata carries
// year, month and day, all zero when the date is invalid.
// Throughput is one character per cycle while s_tready is high. The result
// of a string passes two registers: the edge that accepts its last character
// loads the parsed numbers into the first, and once the output is free the
// checked result is loaded into the second after the calendar check (a 16 by
// 16 multiply for the leap rule and compares).
// When the receiver stalls, the output register holds its result and the
// stage before it can still take one more finished string; s_tready falls
// only when both are full. The year bounds must be written on the cfg_ port
// only while the block is idle; the block does not enforce it. Reset clears
// the parse state, empties both stages and restores the bounds to 1900 and 2100.
module date_string_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // character
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,  // year, month, day, zero pad
	output logic                              m_tuser,  // valid_res
	input  logic                              cfg_we,
	input  logic [dstr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dstr_pkg::NUM_W-1:0]        cfg_data
);
	import dstr_pkg::*;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_NUM1,
		PH_NUM2,
		PH_NUM3,
		PH_DONE,
		PH_FAIL
	} phase_t;

	logic [NUM_W-1:0]   year_lo_q, year_hi_q;
	phase_t             phase_q, ph_eff, ph_n;
	logic [NUM_W-1:0]   acc_q, acc_n, first_q, first_n;
	logic [MONTH_W-1:0] month_q, month_n;
	logic               yf_q, yf_n;

	logic [CHAR_W-1:0]  c;
	logic               c_digit, c_sep;
	logic [PROD_W-1:0]  acc_mul;
	logic [NUM_W-1:0]   acc_add;
	logic               acc_big;

	dstr_cand_t         cand_s1;
	logic               valid_s1;
	dstr_res_t          res_chk, res_s2;
	logic               valid_s2;

	logic               accept, out_free, s1_free;

	assign out_free = !valid_s2 || m_tready;
	assign s1_free  = !valid_s1 || out_free;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s_tready;

	assign c       = s_tdata;
	assign c_digit = is_digit(c);
	assign c_sep   = is_sep(c);
	assign acc_mul = {4'b0000, acc_q} * 20'd10 + {16'b0, c[3:0]};
	assign acc_add = (acc_mul > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_mul[NUM_W-1:0];
	assign acc_big = acc_q > DAY_LIMIT;

	always_comb begin
		ph_eff  = phase_q;
		ph_n    = phase_q;
		acc_n   = acc_q;
		first_n = first_q;
		month_n = month_q;
		yf_n    = yf_q;
		if (phase_q == PH_SKIP && !is_space(c)) begin
			ph_eff = PH_NUM1;
		end
		unique case (ph_eff)
			PH_NUM1: begin
				ph_n = PH_NUM1;
				if (c_digit) begin
					acc_n = acc_add;
				end else begin
					first_n = acc_q;
					yf_n    = acc_big;
					if ((acc_big && !year_ok(acc_q, year_lo_q, year_hi_q)) || !c_sep) begin
						ph_n = PH_FAIL;
					end else begin
						acc_n = '0;
						ph_n  = PH_NUM2;
					end
				end
			end
			PH_NUM2: begin
				if (c_digit) begin
					acc_n = acc_add;
				end else if (acc_q < 16'd1 || acc_q > 16'd12 || !c_sep) begin
					ph_n = PH_FAIL;
				end else begin
					month_n = acc_q[MONTH_W-1:0];
					acc_n   = '0;
					ph_n    = PH_NUM3;
				end
			end
			PH_NUM3: begin
				if (c_digit) begin
					acc_n = acc_add;
				end else begin
					ph_n = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_lo_q <= YEAR_LO_RST;
			year_hi_q <= YEAR_HI_RST;
			phase_q    <= PH_SKIP;
			acc_q      <= '0;
			first_q    <= '0;
			month_q    <= '0;
			yf_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_YEAR_LO) begin
					year_lo_q <= cfg_data;
				end else if (cfg_index == REG_YEAR_HI) begin
					year_hi_q <= cfg_data;
				end
			end
			if (accept) begin
				if (s_tlast) begin
					phase_q <= PH_SKIP;
					acc_q   <= '0;
					first_q <= '0;
					month_q <= '0;
					yf_q    <= 1'b0;
				end else begin
					phase_q <= ph_n;
					acc_q   <= acc_n;
					first_q <= first_n;
					month_q <= month_n;
					yf_q    <= yf_n;
				end
			end
		end
	end

	// The string end counts as a non-digit, so only the third number survives it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && s_tlast) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			cand_s1.done         <= (ph_n == PH_NUM3) || (ph_n == PH_DONE);
			cand_s1.year_first   <= yf_n;
			cand_s1.first_number <= first_n;
			cand_s1.month        <= month_n;
			cand_s1.accumulator  <= acc_n;
		end
	end

	dstr_check u_check (
		.cand     (cand_s1),
		.year_lo  (year_lo_q),
		.year_hi  (year_hi_q),
		.res      (res_chk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			res_s2 <= res_chk;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.valid_res;
	assign m_tdata  = {7'b0, res_s2.day, res_s2.month, res_s2.year};

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("invalid result carries non-zero fields");

	a_valid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[19:16] >= 4'd1 && m_tdata[19:16] <= 4'd12 &&
			m_tdata[24:20] != 5'd0)
		else $error("valid result with month or day out of range");

	a_last_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> valid_s1)
		else $error("last character did not load the first stage");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a full pipeline");

endmodule

/* tb/tb_date_string_parser.sv */
module tb_date_string_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import dstr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [8:0] STRING_END = 9'h100;

	typedef enum logic [2:0] {
		PH_SKIP, PH_NUM1, PH_NUM2, PH_NUM3, PH_DONE, PH_FAIL
	} parse_phase_t;

	class date_scoreboard_t;
		logic [NUM_W-1:0]   lo_year = YEAR_LO_RST;
		logic [NUM_W-1:0]   hi_year = YEAR_HI_RST;
		parse_phase_t       phase = PH_SKIP;
		logic [NUM_W-1:0]   acc = '0;
		logic [NUM_W-1:0]   first_num = '0;
		logic [MONTH_W-1:0] month_val = '0;
		bit                 year_first = 0;
		dstr_res_t          pending[$];
		int                 errors = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] value);
			if (idx == REG_YEAR_LO) begin
				lo_year = value;
			end else if (idx == REG_YEAR_HI) begin
				hi_year = value;
			end
		endfunction

		function bit in_bounds(logic [NUM_W-1:0] y);
			return y >= lo_year && y <= hi_year;
		endfunction

		function int month_len(int unsigned y, int unsigned m);
			bit leap;
			leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11: return 30;
				2: return leap ? 29 : 28;
				default: return 0;
			endcase
		endfunction

		function bit digit_char(logic [8:0] c);
			return c >= {1'b0, CH_ZERO} && c <= {1'b0, CH_NINE};
		endfunction

		function bit blank_char(logic [8:0] c);
			return c == {1'b0, CH_SPACE} || (c >= {1'b0, CH_TAB} && c <= {1'b0, CH_CR});
		endfunction

		function bit sep_char(logic [8:0] c);
			return c == {1'b0, CH_SLASH} || c == {1'b0, CH_BSLASH} || c == {1'b0, CH_DOT} ||
				c == {1'b0, CH_DASH} || c == {1'b0, CH_COLON};
		endfunction

		function void push_digit(logic [8:0] c);
			int unsigned v;
			v = acc * 10 + (c - CH_ZERO);
			acc = (v > ACC_MAX) ? ACC_MAX : v[NUM_W-1:0];
		endfunction

		function void feed(logic [8:0] c);
			if (phase == PH_SKIP) begin
				if (blank_char(c))
					return;
				phase = PH_NUM1;
			end
			if (phase == PH_NUM1) begin
				if (digit_char(c)) begin
					push_digit(c);
					return;
				end
				first_num = acc;
				year_first = acc > DAY_LIMIT;
				if ((year_first && !in_bounds(acc)) || !sep_char(c)) begin
					phase = PH_FAIL;
					return;
				end
				acc = '0;
				phase = PH_NUM2;
				return;
			end
			if (phase == PH_NUM2) begin
				if (digit_char(c)) begin
					push_digit(c);
					return;
				end
				if (acc < 1 || acc > 12 || !sep_char(c)) begin
					phase = PH_FAIL;
					return;
				end
				month_val = acc[MONTH_W-1:0];
				acc = '0;
				phase = PH_NUM3;
				return;
			end
			if (phase == PH_NUM3) begin
				if (digit_char(c)) begin
					push_digit(c);
					return;
				end
				phase = PH_DONE;
			end
		endfunction

		function void note_char(logic [CHAR_W-1:0] c, logic lst);
			dstr_res_t r;
			logic [NUM_W-1:0] y;
			logic [NUM_W-1:0] d;
			bit ok;
			feed({1'b0, c});
			if (!lst)
				return;
			feed(STRING_END);
			r = '0;
			ok = 0;
			y = '0;
			d = '0;
			if (phase == PH_DONE) begin
				if (year_first) begin
					y = first_num;
					d = acc;
					ok = 1;
				end else begin
					y = acc;
					d = first_num;
					ok = in_bounds(y);
				end
				if (ok)
					ok = d > 0 && d <= month_len(y, month_val);
			end
			if (ok) begin
				r.valid_res = 1'b1;
				r.year = y;
				r.month = month_val;
				r.day = d[DAY_W-1:0];
			end
			pending.push_back(r);
			phase = PH_SKIP;
			acc = '0;
			first_num = '0;
			month_val = '0;
			year_first = 0;
		endfunction

		function void check_result(logic [31:0] data, logic flag);
			dstr_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual flag %0d data %h",
					$time, flag, data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (flag !== e.valid_res) begin
				$display("%0t: valid_res expected %0d actual %0d", $time, e.valid_res, flag);
				errors++;
			end
			if (data[15:0] !== e.year) begin
				$display("%0t: year expected %0d actual %0d", $time, e.year, data[15:0]);
				errors++;
			end
			if (data[19:16] !== e.month) begin
				$display("%0t: month expected %0d actual %0d", $time, e.month, data[19:16]);
				errors++;
			end
			if (data[24:20] !== e.day) begin
				$display("%0t: day expected %0d actual %0d", $time, e.day, data[24:20]);
				errors++;
			end
			if (data[31:25] !== 7'd0) begin
				$display("%0t: padding expected 0 actual %h", $time, data[31:25]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NUM_W-1:0]     cfg_data;

	date_scoreboard_t sb = new();
	logic [7:0] text[$];
	bit calm = 0;
	int chars_sent = 0;

	date_string_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_date_string_parser failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready <= 1'b1;
			if (!calm)
				repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	task automatic send_char(input logic [7:0] c, input logic lst);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= lst;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_char(c, lst);
		chars_sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic int unsigned pick_year();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(sb.lo_year, sb.hi_year);
		if (r == 7)
			return $urandom_range(0, 1) ? sb.hi_year + 1 : sb.lo_year - 1;
		if (r == 8) begin
			case ($urandom_range(0, 4))
				0: return 1900;
				1: return 2000;
				2: return 2024;
				3: return 2100;
				default: return 2400;
			endcase
		end
		return $urandom_range(0, 65535);
	endfunction

	function automatic int unsigned pick_month();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return $urandom_range(1, 12);
		if (r == 8)
			return $urandom_range(0, 1) ? 13 : 0;
		return $urandom_range(0, 99);
	endfunction

	function automatic int unsigned pick_day(int unsigned y, int unsigned m);
		int unsigned r;
		int len;
		r = $urandom_range(0, 9);
		len = sb.month_len(y, m);
		if (r < 7)
			return (len > 0) ? $urandom_range(1, len) : $urandom_range(1, 31);
		if (r == 7)
			return len;
		if (r == 8)
			return len + 1;
		return $urandom_range(0, 40);
	endfunction

	function automatic void put_num(int unsigned v);
		string s;
		int unsigned r;
		r = $urandom_range(0, 39);
		if (r == 0)
			return;
		if (r == 1 || (v == 65535 && r < 20))
			v = $urandom_range(65536, 9999999);
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) text.push_back(CH_ZERO);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	function automatic void put_sep();
		case ($urandom_range(0, 4))
			0: text.push_back(CH_SLASH);
			1: text.push_back(CH_BSLASH);
			2: text.push_back(CH_DOT);
			3: text.push_back(CH_DASH);
			default: text.push_back(CH_COLON);
		endcase
	endfunction

	function automatic void make_date();
		int unsigned y;
		int unsigned m;
		int unsigned d;
		text.delete();
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
			text.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
		y = pick_year();
		m = pick_month();
		d = pick_day(y, m);
		if ($urandom_range(0, 1)) begin
			put_num(y);
			put_sep();
			put_num(m);
			put_sep();
			put_num(d);
		end else begin
			put_num(d);
			put_sep();
			put_num(m);
			put_sep();
			put_num(y);
		end
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: text.push_back(CH_SPACE);
				1: text.push_back(CH_DASH);
				2: text.push_back(8'hC3);
				default: text.push_back("T");
			endcase
			repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
		end
		if (text.size() == 0)
			text.push_back(CH_DOT);
	endfunction

	task automatic send_random_string();
		int unsigned r;
		int unsigned idx;
		r = $urandom_range(0, 19);
		if (r < 15) begin
			make_date();
		end else if (r < 18) begin
			make_date();
			idx = $urandom_range(0, text.size() - 1);
			if ($urandom_range(0, 1))
				text[idx] = 8'($urandom_range(0, 255));
			else
				while (text.size() > idx + 1)
					void'(text.pop_back());
		end else begin
			text.delete();
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
		end
		send_text();
	endtask

	task automatic run_phase(input logic [NUM_W-1:0] lo, input logic [NUM_W-1:0] hi,
			input int budget);
		int start;
		wait_idle();
		write_reg(REG_YEAR_LO, lo);
		write_reg(REG_YEAR_HI, hi);
		write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
		write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
		start = chars_sent;
		while (chars_sent - start < budget)
			send_random_string();
	endtask

	initial begin
		logic [NUM_W-1:0] a;
		logic [NUM_W-1:0] b;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_str("29.2.2000");
		send_str("1/2/");
		send_str("\t");
		send_str("3x");
		send_char(8'hFF, 1'b1);
		send_str("5:");
		send_str("99999");

		run_phase(YEAR_LO_RST, YEAR_HI_RST, 130);
		run_phase(16'd0, 16'hFFFF, 130);
		run_phase(16'd0, 16'd0, 100);
		run_phase(16'hFFFF, 16'hFFFF, 100);
		a = 16'($urandom_range(0, 65535));
		b = 16'($urandom_range(0, 65535));
		run_phase(a < b ? a : b, a < b ? b : a, 120);
		calm = 1;
		run_phase(16'd1999, 16'd2030, 100);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_date_string_parser passed");
		else
			$display("tb_date_string_parser failed");
		$finish;
	end

endmodule

/* date_string_parser.f */
sv/dstr_pkg.sv
sv/dstr_check.sv
sv/date_string_parser.sv
tb/tb_date_string_parser.sv
